>>> rtl/nqpt_pkg.sv
package nqpt_pkg;

   localparam int CFG_W       = 13;
   localparam int CFG_RESET   = 64;
   localparam int CFG_MIN     = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int STATUS_W    = 16;
   localparam int CODE_W      = 15;
   localparam int ID_W        = 16;

   localparam logic [ID_W-1:0] ID_FIRST = 16'd1;
   localparam logic [ID_W-1:0] ID_LAST  = 16'hFFFF;

   localparam logic REG_QUEUE_ENTRIES = 1'b0;

   localparam logic KIND_SUBMIT     = 1'b0;
   localparam logic KIND_COMPLETION = 1'b1;

   typedef enum logic [2:0] {
      OUT_SUBMITTED = 3'd0,
      OUT_WAIT      = 3'd1,
      OUT_SKIPPED   = 3'd2,
      OUT_COMPLETED = 3'd3,
      OUT_REJECTED  = 3'd4
   } outcome_type;

   // decoded request held in the queue between front and back
   typedef struct packed {
      logic              kind;
      logic              phase;
      logic [CODE_W-1:0] code;
      logic [ID_W-1:0]   cid;
   } req_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } queue_head_type;

endpackage

>>> rtl/nqpt_csr.sv
module nqpt_csr
   import nqpt_pkg::*;
#(
   parameter int MAX_ENTRIES = 4096,
   localparam int SIZE_W = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [SIZE_W-1:0]     ring_size
);

   localparam int CMP_W = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;
   localparam int RESET_SIZE = (CFG_RESET > MAX_ENTRIES) ? MAX_ENTRIES : CFG_RESET;

   logic [CFG_W-1:0]  queue_entries_ff, queue_entries_in;
   logic [SIZE_W-1:0] ring_size_ff, ring_size_in;
   logic [CMP_W-1:0]  wr_ext;
   logic [CMP_W-1:0]  clamped;
   logic              wr_en;
   logic              sel_entries;

   assign csr_pready  = 1'b1;
   assign sel_entries = (csr_paddr[CSR_ADDR_W-1] == REG_QUEUE_ENTRIES);
   assign wr_en       = csr_psel && csr_penable && csr_pwrite && csr_pready && sel_entries;
   assign wr_ext      = CMP_W'(csr_pwdata[CFG_W-1:0]);

   always_comb begin
      if (wr_ext < CMP_W'(CFG_MIN)) begin
         clamped = CMP_W'(CFG_MIN);
      end else if (wr_ext > CMP_W'(MAX_ENTRIES)) begin
         clamped = CMP_W'(MAX_ENTRIES);
      end else begin
         clamped = wr_ext;
      end
      queue_entries_in = queue_entries_ff;
      ring_size_in     = ring_size_ff;
      if (wr_en) begin
         queue_entries_in = csr_pwdata[CFG_W-1:0];
         ring_size_in     = SIZE_W'(clamped);
      end
   end

   always_comb begin
      if (sel_entries) begin
         csr_prdata = CSR_DATA_W'(queue_entries_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_entries_ff <= CFG_W'(CFG_RESET);
         ring_size_ff     <= SIZE_W'(RESET_SIZE);
      end else begin
         queue_entries_ff <= queue_entries_in;
         ring_size_ff     <= ring_size_in;
      end
   end

   assign ring_size = ring_size_ff;

endmodule

>>> rtl/nqpt_front.sv
module nqpt_front
   import nqpt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2*ID_W-1:0]   req_tdata,
   input  logic                req_tuser,
   output queue_head_type      head,
   input  logic                pop
);

   localparam int DEPTH = 2;

   req_item_type q_ff [DEPTH];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push;
   logic         do_pop;
   req_item_type item;

   // split the request into its fields
   always_comb begin
      item.kind  = req_tuser;
      item.phase = req_tdata[0];
      item.code  = req_tdata[STATUS_W-1:1];
      item.cid   = req_tdata[STATUS_W +: ID_W];
   end

   assign req_tready = (count_ff != 2'(DEPTH));
   assign push       = req_tvalid && req_tready;
   assign do_pop     = pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = q_ff[rd_ptr_ff];

endmodule

>>> rtl/nqpt_back.sv
module nqpt_back
   import nqpt_pkg::*;
#(
   parameter int MAX_ENTRIES = 4096,
   localparam int SIZE_W = $clog2(MAX_ENTRIES + 1),
   localparam int PTR_W  = $clog2(MAX_ENTRIES)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [SIZE_W-1:0]   ring_size,
   input  queue_head_type      head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_tready,
   output outcome_type         outcome,
   output logic [PTR_W-1:0]    slot_index,
   output logic [ID_W-1:0]     assigned_id,
   output logic [PTR_W-1:0]    sq_doorbell_value,
   output logic [PTR_W-1:0]    cq_doorbell_value,
   output logic [PTR_W-1:0]    next_cq_index,
   output logic                success,
   output logic [CODE_W-1:0]   status_code
);

   localparam int CMP_W = (SIZE_W > PTR_W + 1) ? SIZE_W : PTR_W + 1;

   logic [PTR_W-1:0]  sq_tail_ff, sq_tail_in;
   logic [PTR_W-1:0]  cq_head_ff, cq_head_in;
   logic              phase_ff, phase_in;
   logic [ID_W-1:0]   next_id_ff, next_id_in;
   logic [ID_W-1:0]   waiting_id_ff, waiting_id_in;
   logic              busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;

   outcome_type       outcome_ff, outcome_in;
   logic [PTR_W-1:0]  slot_ff, slot_in;
   logic [ID_W-1:0]   aid_ff, aid_in;
   logic [PTR_W-1:0]  sqdb_ff, sqdb_in;
   logic [PTR_W-1:0]  cqdb_ff, cqdb_in;
   logic [PTR_W-1:0]  next_cq_ff, next_cq_in;
   logic              succ_ff, succ_in;
   logic [CODE_W-1:0] code_ff, code_in;

   logic [CMP_W-1:0]  tail_inc;
   logic [CMP_W-1:0]  head_inc;
   logic              tail_wrap;
   logic              head_wrap;
   logic [PTR_W-1:0]  tail_nxt;
   logic [PTR_W-1:0]  head_nxt;

   // an advance that reaches or passes the ring size wraps to zero
   assign tail_inc  = CMP_W'(sq_tail_ff) + CMP_W'(1);
   assign head_inc  = CMP_W'(cq_head_ff) + CMP_W'(1);
   assign tail_wrap = (tail_inc >= CMP_W'(ring_size));
   assign head_wrap = (head_inc >= CMP_W'(ring_size));
   assign tail_nxt  = tail_wrap ? '0 : tail_inc[PTR_W-1:0];
   assign head_nxt  = head_wrap ? '0 : head_inc[PTR_W-1:0];

   assign pop = head.valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      sq_tail_in    = sq_tail_ff;
      cq_head_in    = cq_head_ff;
      phase_in      = phase_ff;
      next_id_in    = next_id_ff;
      waiting_id_in = waiting_id_ff;
      busy_in       = busy_ff;
      outcome_in    = OUT_WAIT;
      slot_in       = '0;
      aid_in        = '0;
      sqdb_in       = '0;
      cqdb_in       = '0;
      succ_in       = 1'b0;
      code_in       = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (pop) begin
         rsp_valid_in = 1'b1;
         if (head.item.kind == KIND_SUBMIT) begin
            if (busy_ff) begin
               outcome_in = OUT_REJECTED;
            end else begin
               outcome_in    = OUT_SUBMITTED;
               slot_in       = sq_tail_ff;
               aid_in        = next_id_ff;
               next_id_in    = (next_id_ff == ID_LAST) ? ID_FIRST : next_id_ff + ID_FIRST;
               sq_tail_in    = tail_nxt;
               sqdb_in       = tail_nxt;
               waiting_id_in = next_id_ff;
               busy_in       = 1'b1;
            end
         end else begin
            if (!busy_ff || (head.item.phase != phase_ff)) begin
               outcome_in = OUT_WAIT;
            end else begin
               cq_head_in = head_nxt;
               phase_in   = head_wrap ? ~phase_ff : phase_ff;
               if (head.item.cid != waiting_id_ff) begin
                  outcome_in = OUT_SKIPPED;
               end else begin
                  outcome_in = OUT_COMPLETED;
                  cqdb_in    = head_nxt;
                  code_in    = head.item.code;
                  succ_in    = (head.item.code == '0);
                  busy_in    = 1'b0;
               end
            end
         end
      end
      next_cq_in = cq_head_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_tail_ff    <= '0;
         cq_head_ff    <= '0;
         phase_ff      <= 1'b1;
         next_id_ff    <= ID_FIRST;
         waiting_id_ff <= '0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sq_tail_ff    <= sq_tail_in;
         cq_head_ff    <= cq_head_in;
         phase_ff      <= phase_in;
         next_id_ff    <= next_id_in;
         waiting_id_ff <= waiting_id_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         outcome_ff <= outcome_in;
         slot_ff    <= slot_in;
         aid_ff     <= aid_in;
         sqdb_ff    <= sqdb_in;
         cqdb_ff    <= cqdb_in;
         next_cq_ff <= next_cq_in;
         succ_ff    <= succ_in;
         code_ff    <= code_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign outcome           = outcome_ff;
   assign slot_index        = slot_ff;
   assign assigned_id       = aid_ff;
   assign sq_doorbell_value = sqdb_ff;
   assign cq_doorbell_value = cqdb_ff;
   assign next_cq_index     = next_cq_ff;
   assign success           = succ_ff;
   assign status_code       = code_ff;

endmodule

>>> rtl/nvme_queue_pair_tracker.sv
// channel   dir  handshake           tdata (low bit up)                     tuser
// req_      in   req_tvalid/tready   entry_status, entry_command_id         kind
// rsp_      out  rsp_tvalid/tready   slot, id, sq db, cq db, next cq, ...   outcome
// csr_      in   psel/penable        queue_entries at byte address 0        -
//
// One request per cycle sustained while rsp_tready stays high; each accepted request passes
// through the front queue and then the back output register before it leaves.
// The 2-entry front queue and the output register let each side stall alone.
// Reset is synchronous; no clearing pass.
module nvme_queue_pair_tracker
   import nqpt_pkg::*;
#(
   parameter int MAX_ENTRIES = 4096,
   localparam int PTR_W    = $clog2(MAX_ENTRIES),
   localparam int SIZE_W   = $clog2(MAX_ENTRIES + 1),
   localparam int RSP_BITS = 4 * PTR_W + ID_W + 1 + CODE_W,
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2*ID_W-1:0]     req_tdata,  // entry_status, entry_command_id
   input  logic                  req_tuser,  // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,  // slot_index, assigned_id, sq_doorbell_value,
                                             // cq_doorbell_value, next_cq_index, success,
                                             // status_code, zero pad
   output logic [2:0]            rsp_tuser,  // outcome
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [SIZE_W-1:0] ring_size;
   queue_head_type    head;
   logic              pop;
   outcome_type       outcome;
   logic [PTR_W-1:0]  slot_index;
   logic [ID_W-1:0]   assigned_id;
   logic [PTR_W-1:0]  sq_doorbell_value;
   logic [PTR_W-1:0]  cq_doorbell_value;
   logic [PTR_W-1:0]  next_cq_index;
   logic              success;
   logic [CODE_W-1:0] status_code;

   nqpt_csr #(.MAX_ENTRIES(MAX_ENTRIES)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ring_size   (ring_size)
   );

   nqpt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .pop        (pop)
   );

   nqpt_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
      .clock             (clock),
      .reset             (reset),
      .ring_size         (ring_size),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .outcome           (outcome),
      .slot_index        (slot_index),
      .assigned_id       (assigned_id),
      .sq_doorbell_value (sq_doorbell_value),
      .cq_doorbell_value (cq_doorbell_value),
      .next_cq_index     (next_cq_index),
      .success           (success),
      .status_code       (status_code)
   );

   assign rsp_tuser = outcome;
   assign rsp_tdata = RSP_W'({status_code, success, next_cq_index, cq_doorbell_value,
                              sq_doorbell_value, assigned_id, slot_index});

endmodule

>>> rtl/nqpt_checker.sv
module nqpt_checker
   import nqpt_pkg::*;
#(
   parameter int MAX_ENTRIES = 4096,
   localparam int PTR_W    = $clog2(MAX_ENTRIES),
   localparam int RSP_BITS = 4 * PTR_W + ID_W + 1 + CODE_W,
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic [2:0]       rsp_tuser
);

   localparam int AID_LO  = PTR_W;
   localparam int SQ_LO   = PTR_W + ID_W;
   localparam int SUCC_LO = 4 * PTR_W + ID_W;
   localparam int CODE_LO = SUCC_LO + 1;

   logic [PTR_W-1:0]  slot_f;
   logic [ID_W-1:0]   aid_f;
   logic [PTR_W-1:0]  sq_f;
   logic              succ_f;
   logic [CODE_W-1:0] code_f;

   assign slot_f = rsp_tdata[0 +: PTR_W];
   assign aid_f  = rsp_tdata[AID_LO +: ID_W];
   assign sq_f   = rsp_tdata[SQ_LO +: PTR_W];
   assign succ_f = rsp_tdata[SUCC_LO];
   assign code_f = rsp_tdata[CODE_LO +: CODE_W];

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_outcome_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= OUT_REJECTED))
      else $error("outcome code out of range");

   a_submit_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == OUT_SUBMITTED) |-> (aid_f != '0))
      else $error("command id zero issued");

   a_nonsubmit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != OUT_SUBMITTED) |->
         (slot_f == '0) && (aid_f == '0) && (sq_f == '0))
      else $error("submit fields set on a non-submit response");

   a_success: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (succ_f == ((rsp_tuser == OUT_COMPLETED) && (code_f == '0))))
      else $error("success flag disagrees with status code");

endmodule

bind nvme_queue_pair_tracker nqpt_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_nqpt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
